/* hdl/tlbfl_pkg.sv */
// ----------------------------------------------------------------------------
// tlbfl_pkg
// Shared types and codes for the fully associative translation buffer.
// ----------------------------------------------------------------------------
package tlbfl_pkg;

	localparam int PAGE_W = 20;
	localparam int FRAME_W = 20;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;

	// action codes
	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_INSERT = 2'd1;
	localparam logic [1:0] ACT_FLUSH = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'd1;

	localparam logic MODE_FIFO = 1'b0;
	localparam logic MODE_LRU = 1'b1;
	localparam logic [CFG_DATA_W-1:0] LIMIT_RESET = 5'd16;

	typedef struct packed {
		logic [1:0] action;
		logic [PAGE_W-1:0] page;
		logic [FRAME_W-1:0] new_frame;
	} in_item_t;

	typedef struct packed {
		logic hit;
		logic [FRAME_W-1:0] frame;
	} out_item_t;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		logic [FRAME_W-1:0] frame;
	} entry_t;

endpackage

/* hdl/tlbfl_order.sv */
// ----------------------------------------------------------------------------
// tlbfl_order
// Age order of the entry slots, oldest first. Holds a permutation of all
// slots: the first held_count positions are live, the rest are free slots.
// ----------------------------------------------------------------------------
module tlbfl_order #(
	parameter int ENTRIES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_pos,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rd_slot,
	output logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] head_slot,
	input logic rot_en,
	input logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rot_lo,
	input logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rot_hi,
	input logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] rot_slot
);
	import tlbfl_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [IW-1:0] ord_q [ENTRIES];
	logic [IW-1:0] ord_nxt [ENTRIES];

	assign rd_slot = ord_q[rd_pos];
	assign head_slot = ord_q[0];

	// rotate positions lo..hi left by one, the moved slot lands at hi
	for (genvar p = 0; p < ENTRIES; p++) begin : g_pos
		logic [IW-1:0] right_slot;
		if (p < ENTRIES - 1) begin : g_mid
			assign right_slot = ord_q[p+1];
		end else begin : g_last
			assign right_slot = ord_q[p];
		end
		always_comb begin
			ord_nxt[p] = ord_q[p];
			if (IW'(p) == rot_hi) begin
				ord_nxt[p] = rot_slot;
			end else if (IW'(p) >= rot_lo && IW'(p) < rot_hi) begin
				ord_nxt[p] = right_slot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < ENTRIES; p++) begin
				ord_q[p] <= IW'(p);
			end
		end else if (rot_en) begin
			ord_q <= ord_nxt;
		end
	end

endmodule

/* hdl/tlb_fifo_lru.sv */
// ----------------------------------------------------------------------------
// tlb_fifo_lru
// Fully associative page translation buffer with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. action selects a
//   lookup, an insert of page/new_frame, or a flush. Every item produces one
//   result transfer: done is high for exactly one cycle with hit/frame.
//   Entries sit in a synchronous RAM with one read and one write port; a
//   small slot list keeps their age order. A lookup scans the list oldest
//   first, one RAM read per cycle, and stops at the first match.
//   Insert, flush, unused codes and a lookup of an empty buffer give done
//   in the cycle after the transfer, and the next item can be taken at once.
//   A lookup of a non-empty buffer keeps busy high while it scans, and gives
//   done in the cycle after the scan step that finds a match or reaches the
//   newest entry.
//   The result is not held: the receiver must take it in the done cycle.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and belong in idle time only.
//   Reset empties the buffer, selects FIFO mode and a limit of 16 entries.
// ----------------------------------------------------------------------------
module tlb_fifo_lru #(
	parameter int ENTRIES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input tlbfl_pkg::in_item_t in_item,
	output logic done,
	output tlbfl_pkg::out_item_t result,
	input logic cfg_we,
	input logic [tlbfl_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [tlbfl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tlbfl_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_SCAN = 2'b10
	} state_t;

	state_t state_q;
	logic mode_q;
	logic [CFG_DATA_W-1:0] limit_q;
	logic [CW-1:0] held_q;
	logic [CW-1:0] pos_q;
	logic [IW-1:0] pos_s1;
	logic [IW-1:0] slot_s1;
	logic [PAGE_W-1:0] page_q;
	logic done_q;
	out_item_t result_q;

	entry_t mem [ENTRIES];
	entry_t mem_rd_q;

	logic [CW-1:0] limit;
	logic accept;
	logic full;
	logic match;
	logic last;
	logic [IW-1:0] rd_pos;
	logic [IW-1:0] rd_slot;
	logic [IW-1:0] head_slot;
	logic rot_en;
	logic [IW-1:0] rot_lo;
	logic [IW-1:0] rot_hi;
	logic [IW-1:0] rot_slot;
	logic wr_en;
	logic [IW-1:0] wr_slot;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign done = done_q;
	assign result = result_q;

	// clamp the limit into 1..ENTRIES
	always_comb begin
		if (limit_q == '0) begin
			limit = CW'(1);
		end else if (32'(limit_q) > ENTRIES) begin
			limit = CW'(ENTRIES);
		end else begin
			limit = CW'(limit_q);
		end
	end

	assign full = (held_q >= limit) && (held_q != '0);
	assign match = (mem_rd_q.page == page_q);
	assign last = (CW'(pos_s1) == held_q - CW'(1));

	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_pos = (in_item.action == ACT_LOOKUP) ? '0 : held_q[IW-1:0];
		end else begin
			rd_pos = pos_q[IW-1:0];
		end
	end

	assign rot_hi = IW'(held_q - CW'(1));
	assign rot_lo = (state_q == ST_IDLE) ? '0 : pos_s1;
	assign rot_slot = (state_q == ST_IDLE) ? head_slot : slot_s1;
	assign wr_en = accept && (in_item.action == ACT_INSERT);
	assign wr_slot = full ? head_slot : rd_slot;

	always_comb begin
		rot_en = 1'b0;
		if (wr_en && full) begin
			rot_en = 1'b1;
		end else if (state_q == ST_SCAN && match && mode_q == MODE_LRU) begin
			rot_en = 1'b1;
		end
	end

	tlbfl_order #(
		.ENTRIES(ENTRIES)
	) u_order (
		.clk(clk),
		.arst_n(arst_n),
		.rd_pos(rd_pos),
		.rd_slot(rd_slot),
		.head_slot(head_slot),
		.rot_en(rot_en),
		.rot_lo(rot_lo),
		.rot_hi(rot_hi),
		.rot_slot(rot_slot)
	);

	// entry ram, one read and one write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_slot] <= '{page: in_item.page, frame: in_item.new_frame};
		end
		mem_rd_q <= mem[rd_slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FIFO;
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE: mode_q <= cfg_data[0];
				CFG_LIMIT: limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= in_item.page;
		end
		if (accept || state_q == ST_SCAN) begin
			slot_s1 <= rd_slot;
		end
		if (accept) begin
			pos_s1 <= '0;
		end else if (state_q == ST_SCAN) begin
			pos_s1 <= pos_q[IW-1:0];
		end
		if (accept) begin
			pos_q <= CW'(1);
		end else if (state_q == ST_SCAN) begin
			pos_q <= pos_q + CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q <= '0;
			done_q <= 1'b0;
			result_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					// every command answers at once except a lookup of a non-empty list
					done_q <= accept && !(in_item.action == ACT_LOOKUP && held_q != '0);
					if (accept) begin
						result_q <= '0;
						case (in_item.action)
							ACT_LOOKUP: begin
								if (held_q != '0) begin
									state_q <= ST_SCAN;
								end
							end
							ACT_INSERT: begin
								if (!full) begin
									held_q <= held_q + CW'(1);
								end
							end
							ACT_FLUSH: begin
								held_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					done_q <= match || last;
					if (match) begin
						result_q <= '{hit: 1'b1, frame: mem_rd_q.frame};
						state_q <= ST_IDLE;
					end else if (last) begin
						result_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					done_q <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* verif/tlb_fifo_lru_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_fifo_lru_test
// Self-checking bench for the translation buffer. A shadow copy of the entry
// list, kept in age order, predicts hit/frame for every accepted command, and
// each done strobe is checked against the oldest prediction. Runs a short
// directed set, then phases of random traffic under several mode and limit
// settings with changing amounts of start idling.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_test;

	import tlbfl_pkg::*;

	localparam int ENTRIES = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 240;
	localparam int NUM_PHASES = 8;
	localparam int POOL_SIZE = 24;
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	class tlb_shadow;
		logic mode;
		logic [CFG_DATA_W-1:0] limit;
		entry_t held[$];
		out_item_t expected[$];
		int unsigned mismatches;

		function new();
			mode = MODE_FIFO;
			limit = LIMIT_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] data);
			if (idx == CFG_MODE) begin
				mode = data[0];
			end else if (idx == CFG_LIMIT) begin
				limit = data;
			end
		endfunction

		function void take_item(in_item_t it);
			out_item_t r;
			entry_t e;
			int pos;
			int cap;
			r = '0;
			pos = -1;
			case (it.action)
				ACT_LOOKUP: begin
					for (int i = 0; i < held.size(); i++) begin
						if (held[i].page == it.page) begin
							pos = i;
							break;
						end
					end
					if (pos >= 0) begin
						r.hit = 1'b1;
						r.frame = held[pos].frame;
						// lru: a hit moves the entry to the newest end
						if (mode == MODE_LRU) begin
							e = held[pos];
							held.delete(pos);
							held.push_back(e);
						end
					end
				end
				ACT_INSERT: begin
					cap = (limit == 0) ? 1 : ((limit > ENTRIES) ? ENTRIES : int'(limit));
					if (held.size() >= cap && held.size() > 0) begin
						void'(held.pop_front());
					end
					e.page = it.page;
					e.frame = it.new_frame;
					if (held.size() < ENTRIES) begin
						held.push_back(e);
					end
				end
				ACT_FLUSH: begin
					held.delete();
				end
				default: begin
				end
			endcase
			expected.push_back(r);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (expected.size() == 0) begin
				$error("result with no transfer pending: hit %0b frame %h",
					got.hit, got.frame);
				mismatches++;
				return;
			end
			want = expected.pop_front();
			if (got.hit !== want.hit) begin
				$error("hit: expected %0b, actual %0b", want.hit, got.hit);
				mismatches++;
			end
			if (got.frame !== want.frame) begin
				$error("frame: expected %h, actual %h", want.frame, got.frame);
				mismatches++;
			end
		endfunction

		function int outstanding();
			return expected.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	in_item_t in_item;
	logic done;
	out_item_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tlb_shadow shadow = new();
	logic [PAGE_W-1:0] page_pool[POOL_SIZE];
	int unsigned cycle_count = 0;

	tlb_fifo_lru #(
		.ENTRIES(ENTRIES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.in_item(in_item),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tlb_fifo_lru_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			shadow.check_result(result);
		end
	end

	// called at a falling edge, returns at a falling edge with start left high
	task automatic send_item(input in_item_t it, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		in_item = it;
		do begin
			@(posedge clk);
		end while (busy);
		shadow.take_item(it);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start = 1'b0;
		@(negedge clk);
		while (shadow.outstanding() != 0 || busy) begin
			@(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		shadow.write_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic in_item_t random_item();
		in_item_t it;
		int unsigned roll;
		roll = $urandom_range(99);
		it.new_frame = FRAME_W'($urandom);
		it.page = PAGE_W'($urandom);
		if (roll < 46) begin
			it.action = ACT_LOOKUP;
			if ($urandom_range(99) < 80) begin
				it.page = page_pool[$urandom_range(POOL_SIZE - 1)];
			end
		end else if (roll < 94) begin
			it.action = ACT_INSERT;
			if ($urandom_range(99) < 80) begin
				it.page = page_pool[$urandom_range(POOL_SIZE - 1)];
			end
		end else if (roll < 97) begin
			it.action = ACT_FLUSH;
		end else begin
			it.action = ACT_UNUSED;
		end
		return it;
	endfunction

	initial begin
		logic phase_mode[NUM_PHASES];
		logic [CFG_DATA_W-1:0] phase_limit[NUM_PHASES];
		int idle_pct;

		phase_mode = '{MODE_FIFO, MODE_LRU, MODE_LRU, MODE_FIFO,
			MODE_LRU, MODE_LRU, MODE_FIFO, MODE_LRU};
		phase_limit = '{5'd16, 5'd16, 5'd4, 5'd0, 5'd1, 5'd31, 5'd31, 5'd9};

		arst_n = 1'b0;
		start = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_MODE;
		cfg_data = '0;

		page_pool[0] = '0;
		page_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			page_pool[i] = PAGE_W'($urandom);
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty buffer, field extremes, duplicate pages, unused code, flush
		send_item('{ACT_LOOKUP, 20'h00000, 20'h00000}, 8);
		send_item('{ACT_FLUSH, 20'h00000, 20'h00000}, 8);
		send_item('{ACT_INSERT, 20'h00000, 20'hFFFFF}, 8);
		send_item('{ACT_INSERT, 20'hFFFFF, 20'h00000}, 8);
		send_item('{ACT_LOOKUP, 20'h00000, 20'h00000}, 8);
		send_item('{ACT_LOOKUP, 20'hFFFFF, 20'hFFFFF}, 8);
		send_item('{ACT_LOOKUP, 20'h12345, 20'h00000}, 8);
		send_item('{ACT_INSERT, 20'h00000, 20'h00ABC}, 8);
		send_item('{ACT_LOOKUP, 20'h00000, 20'h00000}, 8);
		send_item('{ACT_INSERT, 20'h5A5A5, 20'hA5A5A}, 8);
		send_item('{ACT_LOOKUP, 20'h5A5A5, 20'h00000}, 8);
		send_item('{ACT_UNUSED, 20'hFFFFF, 20'hFFFFF}, 8);
		send_item('{ACT_LOOKUP, 20'hFFFFF, 20'hFFFFF}, 8);
		send_item('{ACT_FLUSH, 20'hFFFFF, 20'hFFFFF}, 8);
		send_item('{ACT_LOOKUP, 20'h00000, 20'h00000}, 8);
		send_item('{ACT_INSERT, 20'hA5A5A, 20'h5A5A5}, 8);

		// entries survive across phases, so a lowered limit meets a fuller list
		for (int p = 0; p < NUM_PHASES; p++) begin
			idle_pct = (p < 3) ? 8 : ((p < 6) ? 75 : 0);
			wait_idle();
			write_reg(CFG_MODE, {4'($urandom_range(15)), phase_mode[p]});
			write_reg(CFG_LIMIT, phase_limit[p]);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				send_item(random_item(), idle_pct);
			end
		end

		start = 1'b0;
		while (shadow.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
		if (shadow.mismatches == 0 && shadow.outstanding() == 0) begin
			$display("tlb_fifo_lru_test: done, clean");
		end else begin
			$display("tlb_fifo_lru_test: done, errors");
		end
		$finish;
	end

endmodule

/* files.f */
hdl/tlbfl_pkg.sv
hdl/tlbfl_order.sv
hdl/tlb_fifo_lru.sv
verif/tlb_fifo_lru_test.sv
